@@ rtl/tmr_pkg.sv @@
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared types and constants of the multi-channel countdown timer.
// ----------------------------------------------------------------------------
package tmr_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 16;
   localparam int MAX_RESULTS          = 16;
   localparam int FIRE_CNT_W           = $clog2(MAX_RESULTS + 1);
   localparam int VAL_W                = 16;
   localparam int WORD_W               = 2 * VAL_W;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_SCAN    = 3'd1;
   localparam logic [2:0] MODE_CONFIG  = 3'd2;
   localparam logic [2:0] MODE_ENABLE  = 3'd3;
   localparam logic [2:0] MODE_DISABLE = 3'd4;
   localparam logic [2:0] MODE_RESET   = 3'd5;
   localparam logic [2:0] MODE_SLEEP   = 3'd6;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  channel;
      logic [15:0] timeout_ms;
      logic        auto_reload;
      logic        start_enabled;
      logic [15:0] sleep_ms;
   } req_type;

   typedef struct packed {
      logic        fired;
      logic [3:0]  fired_channel;
      logic        last;
      logic [15:0] sleep_remaining;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

@@ rtl/tmr_mem.sv @@
// ----------------------------------------------------------------------------
// tmr_mem
// Channel word memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmr_mem #(
   parameter int Depth = 16,
   parameter int AddrW = 4,
   parameter int DataW = 32
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [DataW-1:0] rd_data
);

   logic [DataW-1:0] mem_ff [Depth];
   logic [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tmr_out.sv @@
// ----------------------------------------------------------------------------
// tmr_out
// Output register of the response channel.
// ----------------------------------------------------------------------------
module tmr_out (
   input  logic               clock,
   input  logic               reset,
   input  tmr_pkg::push_type  push,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tmr_pkg::rsp_type   rsp_data
);
   import tmr_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/tmr_seq.sv @@
// ----------------------------------------------------------------------------
// tmr_seq
// Request sequencer: walks the channel memory for tick and scan, applies
// single-channel operations and keeps the channel flags and sleep counter.
// ----------------------------------------------------------------------------
module tmr_seq #(
   parameter int NumChannels = 16,
   parameter int IdxW        = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tmr_pkg::req_type            req_data,
   input  logic                        out_free,
   output tmr_pkg::push_type           push,
   output logic                        mem_wr_en,
   output logic [IdxW-1:0]             mem_wr_addr,
   output logic [tmr_pkg::WORD_W-1:0]  mem_wr_data,
   output logic [IdxW-1:0]             mem_rd_addr,
   input  logic [tmr_pkg::WORD_W-1:0]  mem_rd_data
);
   import tmr_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_OP, S_FINISH} state_type;

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic [IdxW-1:0]        idx_ff, idx_in;
   logic [FIRE_CNT_W-1:0]  fire_cnt_ff, fire_cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [3:0]             pend_ch_ff, pend_ch_in;
   logic [VAL_W-1:0]       sleep_ff, sleep_in;
   logic [NumChannels-1:0] present_ff, present_in;
   logic [NumChannels-1:0] enabled_ff, enabled_in;
   logic [NumChannels-1:0] expired_ff, expired_in;
   logic [NumChannels-1:0] reload_ff, reload_in;

   logic [VAL_W-1:0] tmo_rd, cnt_rd;
   logic [31:0]      ch_wide, idx_wide, item_ch_wide;
   logic [IdxW-1:0]  ch_idx;
   logic [3:0]       idx4;
   logic             last_idx, ch_ok, fire_ok, advance;

   assign tmo_rd       = mem_rd_data[WORD_W-1:VAL_W];
   assign cnt_rd       = mem_rd_data[VAL_W-1:0];
   assign ch_wide      = 32'(req_data.channel);
   assign ch_idx       = ch_wide[IdxW-1:0];
   assign idx_wide     = 32'(idx_ff);
   assign idx4         = idx_wide[3:0];
   assign item_ch_wide = 32'(item_ff.channel);
   assign ch_ok        = item_ch_wide < 32'(NumChannels);
   assign last_idx     = idx_wide == 32'(NumChannels - 1);
   assign fire_ok      = present_ff[idx_ff] && enabled_ff[idx_ff] && !expired_ff[idx_ff] &&
                         (cnt_rd == '0) && (fire_cnt_ff < FIRE_CNT_W'(MAX_RESULTS));

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      sleep_in      = sleep_ff;
      present_in    = present_ff;
      enabled_in    = enabled_ff;
      expired_in    = expired_ff;
      reload_in     = reload_ff;
      push          = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_addr   = idx_ff;
      advance       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in       = req_data;
               fire_cnt_in   = '0;
               pend_valid_in = 1'b0;
               case (req_data.mode) inside
                  MODE_TICK, MODE_SCAN: begin
                     idx_in   = '0;
                     state_in = S_WALK;
                  end
                  MODE_CONFIG, MODE_ENABLE, MODE_DISABLE, MODE_RESET: begin
                     idx_in   = ch_idx;
                     state_in = S_OP;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
               if (req_data.mode == MODE_TICK && sleep_ff != '0) begin
                  sleep_in = sleep_ff - VAL_W'(1);
               end
               if (req_data.mode == MODE_SLEEP) begin
                  sleep_in = req_data.sleep_ms;
               end
               mem_rd_addr = idx_in;
            end
         end

         S_WALK: begin
            if (item_ff.mode == MODE_TICK) begin
               if (present_ff[idx_ff] && enabled_ff[idx_ff] && cnt_rd != '0) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {tmo_rd, cnt_rd - VAL_W'(1)};
               end
            end else if (fire_ok) begin
               // A found channel releases the one held back, which is not last.
               if (pend_valid_ff && !out_free) begin
                  advance = 1'b0;
               end else begin
                  push.valid                = pend_valid_ff;
                  push.data.fired           = 1'b1;
                  push.data.fired_channel   = pend_ch_ff;
                  push.data.last            = 1'b0;
                  push.data.sleep_remaining = sleep_ff;
                  pend_valid_in             = 1'b1;
                  pend_ch_in                = idx4;
                  fire_cnt_in               = fire_cnt_ff + FIRE_CNT_W'(1);
                  if (reload_ff[idx_ff]) begin
                     enabled_in[idx_ff] = 1'b1;
                     expired_in[idx_ff] = 1'b0;
                     mem_wr_en          = 1'b1;
                     mem_wr_data        = {tmo_rd, tmo_rd};
                  end else begin
                     expired_in[idx_ff] = 1'b1;
                  end
               end
            end
            if (advance) begin
               idx_in      = idx_ff + IdxW'(1);
               mem_rd_addr = idx_in;
               if (last_idx) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_OP: begin
            case (item_ff.mode)
               MODE_CONFIG: begin
                  if (ch_ok) begin
                     present_in[idx_ff] = 1'b1;
                     reload_in[idx_ff]  = item_ff.auto_reload;
                     enabled_in[idx_ff] = item_ff.start_enabled;
                     expired_in[idx_ff] = 1'b0;
                     mem_wr_en          = 1'b1;
                     mem_wr_data        = {item_ff.timeout_ms, item_ff.timeout_ms};
                  end
               end
               MODE_ENABLE: begin
                  if (ch_ok && present_ff[idx_ff]) begin
                     if (!enabled_ff[idx_ff]) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {tmo_rd, tmo_rd};
                     end
                     enabled_in[idx_ff] = 1'b1;
                     expired_in[idx_ff] = 1'b0;
                  end
               end
               MODE_DISABLE: begin
                  if (ch_ok && present_ff[idx_ff]) begin
                     enabled_in[idx_ff] = 1'b0;
                  end
               end
               MODE_RESET: begin
                  if (ch_ok && present_ff[idx_ff]) begin
                     enabled_in[idx_ff] = 1'b1;
                     expired_in[idx_ff] = 1'b0;
                     mem_wr_en          = 1'b1;
                     mem_wr_data        = {tmo_rd, tmo_rd};
                  end
               end
               default: begin
               end
            endcase
            state_in = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) begin
               push.valid                = 1'b1;
               push.data.fired           = pend_valid_ff;
               push.data.fired_channel   = pend_valid_ff ? pend_ch_ff : 4'd0;
               push.data.last            = 1'b1;
               push.data.sleep_remaining = sleep_ff;
               pend_valid_in             = 1'b0;
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fire_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         sleep_ff      <= '0;
         present_ff    <= '0;
         enabled_ff    <= '0;
         expired_ff    <= '0;
         reload_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         fire_cnt_ff   <= fire_cnt_in;
         pend_valid_ff <= pend_valid_in;
         sleep_ff      <= sleep_in;
         present_ff    <= present_in;
         enabled_ff    <= enabled_in;
         expired_ff    <= expired_in;
         reload_ff     <= reload_in;
      end
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      pend_ch_ff <= pend_ch_in;
   end

`ifndef ASSERT_OFF
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("response pushed while output register is held");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_WALK || state_ff == S_OP))
      else $error("memory write outside a channel visit");

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FIRE_CNT_W'(MAX_RESULTS))
      else $error("scan reported more channels than allowed");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held response left behind at idle");

   a_last_finish: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.data.last == (state_ff == S_FINISH)))
      else $error("last flag does not match the closing response");
`endif

endmodule

@@ rtl/multi_channel_countdown_timer_top.sv @@
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_top
// Bank of countdown channels with auto-reload, tick, scan and per-channel
// control, with timeout and count held in one channel memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  tmr_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall  tmr_pkg::rsp_type
//
// Tick and scan walk the channel memory: the sequencer visits one memory word
// a cycle between the accept and closing cycles unless a scan pauses.
// Configure, enable, disable and reset read, write back and respond; set
// sleep and unused modes go from accept straight to respond. A scan pauses
// on a stalled output while it holds a found channel, and every request
// waits in its closing cycle while the output register holds a stalled
// response. Reset clears the flag registers at once; the memory needs no
// clearing since an absent channel's word is never used.
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_top #(
   parameter int NumChannels = tmr_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tmr_pkg::rsp_type rsp_data
);
   import tmr_pkg::*;

   localparam int IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

   push_type          push;
   logic              out_free;
   logic              mem_wr_en;
   logic [IdxW-1:0]   mem_wr_addr, mem_rd_addr;
   logic [WORD_W-1:0] mem_wr_data, mem_rd_data;

   tmr_mem #(
      .Depth (NumChannels),
      .AddrW (IdxW),
      .DataW (WORD_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tmr_seq #(
      .NumChannels (NumChannels),
      .IdxW        (IdxW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .out_free    (out_free),
      .push        (push),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   tmr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
